// ===== hdl/bole_pkg.sv =====
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

   localparam int unsigned CMD_W    = 4;
   localparam int unsigned POS_W    = 8;
   localparam int unsigned OPND_W   = 32;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned TOTAL_W  = 7;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_APPEND     = 4'd1,
      CMD_INSERT     = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_POP_BACK   = 4'd4,
      CMD_EXTRACT    = 4'd5,
      CMD_REMOVE     = 4'd6,
      CMD_READ       = 4'd7,
      CMD_WRITE      = 4'd8,
      CMD_CLEAR      = 4'd9
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_SHIFT_IN  = 3'd1,
      CELL_SHIFT_OUT = 3'd2,
      CELL_ROTATE    = 3'd3,
      CELL_WRITE     = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        keep;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

endpackage

// ===== hdl/bole_ifs.sv =====
// Request and response channel interfaces of the list engine.
interface bole_req_if import bole_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [POS_W-1:0]  position;
   logic signed [OPND_W-1:0] operand_value;

   modport source (output valid, output cmd, output position, output operand_value,
                   input ready);
   modport sink   (input valid, input cmd, input position, input operand_value,
                   output ready);
endinterface

interface bole_rsp_if import bole_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result_value;
   logic [TOTAL_W-1:0]         removed_total;
   logic [TOTAL_W-1:0]         length_after;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output result_value, output removed_total,
                   output length_after, output status, input ready);
   modport sink   (input valid, input result_value, input removed_total,
                   input length_after, input status, output ready);
endinterface

// ===== hdl/bole_cell.sv =====
// One list slot: holds an entry and takes a neighbor's entry on shifts.
module bole_cell import bole_pkg::*; #(
   parameter int unsigned INDEX      = 0,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned IDX_W      = 6
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]      at,
   input  logic [VALUE_BITS-1:0] din,
   input  logic [VALUE_BITS-1:0] left,
   input  logic [VALUE_BITS-1:0] right,
   output logic [VALUE_BITS-1:0] q
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_SHIFT_IN: begin
            if (MY_IDX > at) begin
               entry_in = left;
            end else if (MY_IDX == at) begin
               entry_in = din;
            end
         end
         CELL_SHIFT_OUT: begin
            if (MY_IDX >= at) begin
               entry_in = right;
            end
         end
         CELL_ROTATE: begin
            if (MY_IDX < at) begin
               entry_in = right;
            end else if (MY_IDX == at && ctrl.keep) begin
               entry_in = din;
            end
         end
         CELL_WRITE: begin
            if (MY_IDX == at) begin
               entry_in = din;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== hdl/bole_chain.sv =====
// Row of list cells with front tap and indexed read select.
module bole_chain import bole_pkg::*; #(
   parameter int unsigned CAPACITY   = 64,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned IDX_W      = 6
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]      at,
   input  logic [VALUE_BITS-1:0] din,
   input  logic [IDX_W-1:0]      rd_at,
   output logic [VALUE_BITS-1:0] head,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] q [CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_BITS-1:0] left;
      logic [VALUE_BITS-1:0] right;

      if (g == 0) begin : g_left
         assign left = '0;
      end else begin : g_left
         assign left = q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_right
         assign right = '0;
      end else begin : g_right
         assign right = q[g+1];
      end

      bole_cell #(
         .INDEX      (g),
         .VALUE_BITS (VALUE_BITS),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock (clock),
         .ctrl  (ctrl),
         .at    (at),
         .din   (din),
         .left  (left),
         .right (right),
         .q     (q[g])
      );
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (IDX_W'(i) == rd_at) begin
            rd_data = q[i];
         end
      end
   end

   assign head = q[0];

endmodule

// ===== hdl/bounded_ordered_list_engine.sv =====
// Bounded ordered list engine: command sequencer over a chain of list cells.
// A request beat moves the sequencer to execute, which registers the response when the
// response channel can take it; remove value first rotates the chain, one step per entry.
// The next command is accepted only once the previous response is registered; the
// rotation of the cell chain through its front sets the remove time.
// Reset clears the entry count, sequencer state and response valid; cells hold.
module bounded_ordered_list_engine import bole_pkg::*; #(
   parameter int unsigned CAPACITY   = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   bole_req_if.sink   req_bus,
   bole_rsp_if.source rsp_bus
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   cmd_type               cmd_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [VALUE_BITS-1:0] opnd_ff;
   logic [CNT_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]      steps_ff, steps_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] result_ff, result_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   status_type            status_ff, status_in;

   logic                  req_fire;
   logic                  can_out;
   logic                  full;
   logic                  pos_neg;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  ins_ok;
   logic                  idx_ok;
   logic [IDX_W-1:0]      cnt_idx;
   logic [IDX_W-1:0]      last_idx;

   cell_op_type           exec_op;
   logic [IDX_W-1:0]      exec_at;
   logic [VALUE_BITS-1:0] exec_din;
   logic [VALUE_BITS-1:0] exec_res;
   logic                  exec_use_rd;
   status_type            exec_status;
   logic [CNT_W-1:0]      exec_cnt;
   logic                  go_scan;
   logic                  exec_fire;

   logic                  scan_keep;
   logic                  scan_last;
   logic                  scan_adv;
   logic [CNT_W-1:0]      scan_cnt_next;
   logic [CNT_W-1:0]      removed_next;

   cell_ctrl_type         ctrl;
   logic [IDX_W-1:0]      chain_at;
   logic [VALUE_BITS-1:0] chain_din;
   logic [VALUE_BITS-1:0] head;
   logic [VALUE_BITS-1:0] rd_data;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign can_out  = !rsp_valid_ff || rsp_bus.ready;

   assign full     = (count_ff >= CNT_MAX);
   assign pos_neg  = pos_ff[POS_W-1];
   assign pos_ext  = CMP_W'(pos_ff[POS_W-2:0]);
   assign cnt_ext  = CMP_W'(count_ff);
   assign ins_ok   = !pos_neg && (pos_ext <= cnt_ext);
   assign idx_ok   = !pos_neg && (pos_ext < cnt_ext);
   assign cnt_idx  = IDX_W'(count_ff);
   assign last_idx = IDX_W'(count_ff - CNT_ONE);

   always_comb begin
      exec_op     = CELL_HOLD;
      exec_at     = '0;
      exec_din    = opnd_ff;
      exec_use_rd = 1'b0;
      exec_status = STATUS_OK;
      exec_cnt    = count_ff;
      go_scan     = 1'b0;
      unique case (cmd_ff) inside
         CMD_PUSH_FRONT, CMD_APPEND: begin
            if (full) begin
               exec_status = STATUS_FULL;
            end else begin
               exec_op  = CELL_SHIFT_IN;
               exec_at  = (cmd_ff == CMD_PUSH_FRONT) ? '0 : cnt_idx;
               exec_cnt = count_ff + CNT_ONE;
            end
         end
         CMD_INSERT: begin
            if (!ins_ok) begin
               exec_status = STATUS_BAD;
            end else if (full) begin
               exec_status = STATUS_FULL;
            end else begin
               exec_op  = CELL_SHIFT_IN;
               exec_at  = IDX_W'(pos_ext);
               exec_cnt = count_ff + CNT_ONE;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (count_ff == '0) begin
               exec_status = STATUS_BAD;
            end else begin
               exec_op     = (cmd_ff == CMD_POP_FRONT) ? CELL_SHIFT_OUT : CELL_HOLD;
               exec_at     = (cmd_ff == CMD_POP_FRONT) ? '0 : last_idx;
               exec_use_rd = 1'b1;
               exec_cnt    = count_ff - CNT_ONE;
            end
         end
         CMD_EXTRACT: begin
            if (!idx_ok) begin
               exec_status = STATUS_BAD;
            end else begin
               exec_op     = CELL_SHIFT_OUT;
               exec_at     = IDX_W'(pos_ext);
               exec_use_rd = 1'b1;
               exec_cnt    = count_ff - CNT_ONE;
            end
         end
         CMD_REMOVE: begin
            go_scan = (count_ff != '0);
         end
         CMD_READ, CMD_WRITE: begin
            if (idx_ok) begin
               exec_at     = IDX_W'(pos_ext);
               exec_op     = (cmd_ff == CMD_WRITE) ? CELL_WRITE : CELL_HOLD;
               exec_use_rd = (cmd_ff == CMD_READ);
            end else if (full) begin
               exec_status = STATUS_FULL;
            end else begin
               exec_op  = CELL_SHIFT_IN;
               exec_at  = pos_neg ? '0 : cnt_idx;
               exec_din = (cmd_ff == CMD_WRITE) ? opnd_ff : '0;
               exec_cnt = count_ff + CNT_ONE;
            end
         end
         CMD_CLEAR: begin
            exec_cnt = '0;
         end
         default: begin
            exec_status = STATUS_BAD;
         end
      endcase
   end

   assign exec_res  = exec_use_rd ? rd_data : '0;
   assign exec_fire = (state_ff == ST_EXEC) && !go_scan && can_out;

   assign scan_keep     = (head != opnd_ff);
   assign scan_last     = (steps_ff == CNT_ONE);
   assign scan_adv      = (state_ff == ST_SCAN) && (!scan_last || can_out);
   assign scan_cnt_next = scan_keep ? scan_cnt_ff : scan_cnt_ff - CNT_ONE;
   assign removed_next  = scan_keep ? removed_ff : removed_ff + CNT_ONE;

   always_comb begin
      ctrl.op   = CELL_HOLD;
      ctrl.keep = 1'b0;
      chain_at  = exec_at;
      chain_din = exec_din;
      if (exec_fire) begin
         ctrl.op = exec_op;
      end else if (scan_adv) begin
         ctrl.op   = CELL_ROTATE;
         ctrl.keep = scan_keep;
         chain_at  = IDX_W'(scan_cnt_ff - CNT_ONE);
         chain_din = head;
      end
   end

   bole_chain #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W)
   ) u_chain (
      .clock   (clock),
      .ctrl    (ctrl),
      .at      (chain_at),
      .din     (chain_din),
      .rd_at   (exec_at),
      .head    (head),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_cnt_in  = scan_cnt_ff;
      steps_in     = steps_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      result_in    = result_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go_scan) begin
               state_in    = ST_SCAN;
               scan_cnt_in = count_ff;
               steps_in    = count_ff;
               removed_in  = '0;
            end else if (can_out) begin
               state_in     = ST_IDLE;
               count_in     = exec_cnt;
               rsp_valid_in = 1'b1;
               result_in    = exec_res;
               total_in     = '0;
               status_in    = exec_status;
            end
         end
         ST_SCAN: begin
            if (scan_adv) begin
               scan_cnt_in = scan_cnt_next;
               removed_in  = removed_next;
               steps_in    = steps_ff - CNT_ONE;
               if (scan_last) begin
                  state_in     = ST_IDLE;
                  count_in     = scan_cnt_next;
                  rsp_valid_in = 1'b1;
                  result_in    = '0;
                  total_in     = removed_next;
                  status_in    = STATUS_OK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req_bus.cmd);
         pos_ff  <= req_bus.position;
         opnd_ff <= VALUE_BITS'(unsigned'(req_bus.operand_value));
      end
      scan_cnt_ff <= scan_cnt_in;
      steps_ff    <= steps_in;
      removed_ff  <= removed_in;
      result_ff   <= result_in;
      total_ff    <= total_in;
      status_ff   <= status_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_value  = signed'(RESULT_W'(result_ff));
   assign rsp_bus.removed_total = TOTAL_W'(total_ff);
   assign rsp_bus.length_after  = TOTAL_W'(count_ff);
   assign rsp_bus.status        = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("request beat not followed by execute");

   a_scan_balance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_cnt_ff + removed_ff == count_ff)
      else $error("remove scan lost track of entries");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> steps_ff != '0 && steps_ff <= scan_cnt_ff)
      else $error("remove scan step count out of range");

endmodule

// ===== dv/bounded_ordered_list_engine_tb.sv =====
// Testbench for the bounded ordered list engine: directed table and random command beats.
module bounded_ordered_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bole_pkg::*;

   localparam int unsigned CAPACITY     = 64;
   localparam int unsigned VALUE_BITS   = 32;
   localparam int unsigned RANDOM_BEATS = 1050;
   localparam int unsigned PHASE_BEATS  = 150;
   localparam int unsigned IDLE_PCT     = 27;
   localparam int unsigned REPORT_MAX   = 10;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'hA;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'hF;

   localparam int MODE_FILL  = 0;
   localparam int MODE_MIXED = 1;
   localparam int MODE_DRAIN = 2;

   // weights by command code, last slot for undefined codes
   localparam int unsigned CMD_WEIGHT [3][11] = '{
      '{20, 15, 15,  3,  3,  5,  3,  5, 10, 1, 1},
      '{10, 10, 10, 10, 10, 10,  8, 10, 10, 2, 3},
      '{ 3,  3,  3, 20, 20, 20, 12,  5,  5, 2, 2}
   };

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic [TOTAL_W-1:0]  removed;
      logic [TOTAL_W-1:0]  length;
      status_type          status;
   } list_outcome_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic signed [POS_W-1:0] pos;
      logic [OPND_W-1:0]       val;
      logic                    fixed_outcome;
      list_outcome_type        outcome;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   bole_req_if req_bus ();
   bole_rsp_if rsp_bus ();

   bounded_ordered_list_engine #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   logic [VALUE_BITS-1:0] list_entries [CAPACITY];
   int unsigned           list_count = 0;
   list_outcome_type      expected_outcomes [$];
   int unsigned           fault_count = 0;
   bit                    steady_flow = 1'b0;

   function automatic void open_gap(int unsigned at, logic [VALUE_BITS-1:0] v);
      int unsigned i;
      for (i = list_count; i > at; i--) list_entries[i] = list_entries[i-1];
      list_entries[at] = v;
      list_count++;
   endfunction

   function automatic logic [VALUE_BITS-1:0] close_gap(int unsigned at);
      logic [VALUE_BITS-1:0] v;
      int unsigned i;
      v = list_entries[at];
      for (i = at; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
      list_count--;
      return v;
   endfunction

   function automatic list_outcome_type apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                       logic signed [POS_W-1:0] pos,
                                                       logic [OPND_W-1:0] val);
      list_outcome_type o;
      int p;
      int unsigned at, r, w;
      bit full;
      o = '0;
      o.status = STATUS_OK;
      p = pos;
      at = 0;
      full = list_count >= CAPACITY;
      case (cmd) inside
         CMD_PUSH_FRONT, CMD_APPEND: begin
            if (full) o.status = STATUS_FULL;
            else open_gap((cmd == CMD_PUSH_FRONT) ? 0 : list_count, val);
         end
         CMD_INSERT: begin
            if (p < 0 || p > int'(list_count)) o.status = STATUS_BAD;
            else if (full) o.status = STATUS_FULL;
            else open_gap(p, val);
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (list_count == 0) o.status = STATUS_BAD;
            else o.value = close_gap((cmd == CMD_POP_FRONT) ? 0 : list_count - 1);
         end
         CMD_EXTRACT: begin
            if (p < 0 || p >= int'(list_count)) o.status = STATUS_BAD;
            else o.value = close_gap(p);
         end
         CMD_REMOVE: begin
            w = 0;
            for (r = 0; r < list_count; r++) begin
               if (list_entries[r] == val) begin
                  o.removed = o.removed + 1'b1;
               end else begin
                  list_entries[w] = list_entries[r];
                  w++;
               end
            end
            list_count = w;
         end
         CMD_READ, CMD_WRITE: begin
            if (p < 0 || p >= int'(list_count)) begin
               if (full) begin
                  o.status = STATUS_FULL;
               end else begin
                  at = (p < 0) ? 0 : list_count;
                  open_gap(at, '0);
               end
            end else begin
               at = p;
            end
            if (o.status == STATUS_OK) begin
               if (cmd == CMD_READ) o.value = list_entries[at];
               else list_entries[at] = val;
            end
         end
         CMD_CLEAR: list_count = 0;
         default: o.status = STATUS_BAD;
      endcase
      o.length = TOTAL_W'(list_count);
      return o;
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(int mode);
      int unsigned total, roll, k;
      total = 0;
      for (k = 0; k < 11; k++) total += CMD_WEIGHT[mode][k];
      roll = $urandom_range(total - 1);
      k = 0;
      while (roll >= CMD_WEIGHT[mode][k]) begin
         roll -= CMD_WEIGHT[mode][k];
         k++;
      end
      if (k == 10) return CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
      return CMD_W'(k);
   endfunction

   function automatic logic signed [POS_W-1:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return POS_W'($urandom_range(list_count));
      if (roll < 80) return -8'sd1;
      if (roll < 85) return POS_W'(CAPACITY);
      return POS_W'($urandom);
   endfunction

   function automatic logic [OPND_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 4) return OPND_W'($urandom_range(3));
      if (roll < 6) begin
         case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // present one beat from the falling edge, return at the accepting rising edge
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] pos,
                           logic [OPND_W-1:0] val, bit fixed_outcome,
                           list_outcome_type typed_outcome);
      list_outcome_type predicted;
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.position      <= pos;
      req_bus.operand_value <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_list_cmd(cmd, pos, val);
      expected_outcomes.insert(expected_outcomes.size(),
                               fixed_outcome ? typed_outcome : predicted);
   endtask

   always @(negedge clock) rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin : check_beat
      list_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected response beat at %0t: value %h length %0d status %0d",
                        $realtime, rsp_bus.result_value, rsp_bus.length_after,
                        rsp_bus.status);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_bus.result_value !== want.value ||
                rsp_bus.removed_total !== want.removed ||
                rsp_bus.length_after !== want.length ||
                rsp_bus.status !== want.status) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display({"mismatch at %0t: expected value %h removed %0d length %0d",
                            " status %0d, got value %h removed %0d length %0d status %0d"},
                           $realtime, want.value, want.removed, want.length, want.status,
                           rsp_bus.result_value, rsp_bus.removed_total,
                           rsp_bus.length_after, rsp_bus.status);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows [24];
      int unsigned n;
      int mode;
      directed_rows = '{
         '{CMD_POP_FRONT,  8'sd0,    32'h0000_0000, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_BAD}},
         '{CMD_POP_BACK,   8'sd0,    32'h0000_0000, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_BAD}},
         '{CMD_EXTRACT,    8'sd0,    32'h0000_0000, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_BAD}},
         '{CMD_REMOVE,     8'sd0,    32'h0000_0005, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_OK}},
         '{CMD_INSERT,     8'sd1,    32'h0000_0001, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_BAD}},
         '{CMD_INSERT,     -8'sd1,   32'h0000_0001, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_BAD}},
         '{CMD_READ,       -8'sd1,   32'h0000_0000, 1'b1, '{32'h0, 7'd0, 7'd1, STATUS_OK}},
         '{CMD_WRITE,      8'sd64,   32'h7FFF_FFFF, 1'b0, '0},
         '{CMD_PUSH_FRONT, 8'sd0,    32'h8000_0000, 1'b0, '0},
         '{CMD_APPEND,     8'sd0,    32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_INSERT,     8'sd2,    32'h1234_5678, 1'b0, '0},
         '{CMD_INSERT,     8'sd5,    32'h0000_0001, 1'b0, '0},
         '{CMD_READ,       8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_READ,       8'sd127,  32'h0000_0000, 1'b0, '0},
         '{CMD_READ,       -8'sd128, 32'h0000_0000, 1'b0, '0},
         '{CMD_WRITE,      8'sd3,    32'h0000_0000, 1'b0, '0},
         '{CMD_EXTRACT,    8'sd2,    32'h0000_0000, 1'b0, '0},
         '{CMD_EXTRACT,    8'sd63,   32'h0000_0000, 1'b0, '0},
         '{CMD_POP_FRONT,  8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_POP_BACK,   8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_REMOVE,     8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_UNKNOWN_LO, 8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_UNKNOWN_HI, 8'sd0,    32'h0000_0000, 1'b0, '0},
         '{CMD_CLEAR,      8'sd0,    32'h0000_0000, 1'b1, '{32'h0, 7'd0, 7'd0, STATUS_OK}}
      };
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_PUSH_FRONT;
      req_bus.position      = '0;
      req_bus.operand_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_cmd(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                  directed_rows[i].fixed_outcome, directed_rows[i].outcome);

      for (n = 0; n < RANDOM_BEATS; n++) begin
         steady_flow = (n >= 300 && n < 450);
         if (n == 600) begin
            // hold off until the engine has answered everything
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (expected_outcomes.size() != 0) @(negedge clock);
         end
         mode = (n / PHASE_BEATS) % 3;
         send_cmd(pick_cmd(mode), pick_position(), pick_value(), 1'b0, '0);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);
      if (fault_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
